/* hdl/lsbse_pkg.sv */
// Shared definitions for the LSB steganography embed/extract block.
// Register indexes, address width and field widths. No dependencies.
package lsbse_pkg;

    localparam int ADDR_W     = 4;
    localparam int CFG_DATA_W = 32;
    localparam int BUF_W      = 16;
    localparam int CNT_W      = 5;
    localparam int LEN_W      = 32;
    localparam int K_W        = 4;

    localparam logic [1:0] REG_MODE_SEL = 2'd0;
    localparam logic [1:0] REG_BITS_PER = 2'd1;
    localparam logic [1:0] REG_PAY_LEN  = 2'd2;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic CMD_SECRET = 1'b0;
    localparam logic CMD_COVER  = 1'b1;

    localparam logic [K_W-1:0] K_MIN = 4'd1;
    localparam logic [K_W-1:0] K_MAX = 4'd8;

endpackage

/* hdl/lsb_stego_embed_extract.sv */
// LSB steganography embed/extract over a stream of cover channel bytes.
// Top level and only module; depends on lsbse_pkg.
//
// For each accepted word the bit buffer, its fill count and the byte
// counter update at the accept edge, and any result word is loaded into
// the output register the same edge, so one word per clock is
// sustained while m_tready stays high. The input side stalls only when the
// output register is full and not being drained. In embed mode, secret pushes
// (tuser = 0) give no result and each cover byte gives one; in extract mode a
// result comes for each completed secret byte. Any register write restarts
// the stream and should be done while the block is idle.
module lsb_stego_embed_extract
    import lsbse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // tdata: data_in[7:0]
    input  logic [7:0]            s_tdata,
    // tuser: cmd[0]
    input  logic [0:0]            s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: data_out[7:0], need_secret[8], underrun[9], done_res[10], zeros above
    output logic [15:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             mode_reg, mode_next;
    logic [K_W-1:0]   bpc_reg, bpc_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] bcnt_reg, bcnt_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_need_reg, m_need_next;
    logic       m_under_reg, m_under_next;
    logic       m_done_reg, m_done_next;

    logic       accept;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[3:2];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_done_reg, m_under_reg, m_need_reg, m_data_reg};

    always_comb begin
        case (cfg_idx)
            REG_MODE_SEL: prdata = {31'd0, mode_reg};
            REG_BITS_PER: prdata = {28'd0, bpc_reg};
            REG_PAY_LEN:  prdata = plen_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        logic [K_W-1:0]   k;
        logic [7:0]       kmask;
        logic             all_pushed;
        logic [3:0]       n;
        logic [3:0]       sh;
        logic [7:0]       nmask;
        logic [7:0]       chunk;
        logic [2:0]       pos;
        logic [7:0]       res;
        logic [CNT_W-1:0] cnt_e;
        logic [CNT_W-1:0] cnt_b;
        logic [BUF_W-1:0] buf_b;
        logic [BUF_W-1:0] ext_buf;
        logic [CNT_W-1:0] ext_cnt;
        logic [CNT_W-1:0] ext_rem;

        // Out-of-range K values clamp to the nearest legal one.
        if (bpc_reg < K_MIN) begin
            k = K_MIN;
        end else if (bpc_reg > K_MAX) begin
            k = K_MAX;
        end else begin
            k = bpc_reg;
        end
        kmask      = 8'((9'd1 << k) - 9'd1);
        all_pushed = bcnt_reg >= plen_reg;

        // Embed: take up to K of the oldest buffered bits.
        n     = (cnt_reg < {1'b0, k}) ? cnt_reg[3:0] : k;
        sh    = 4'(cnt_reg - {1'b0, n});
        nmask = 8'((9'd1 << n) - 9'd1);
        chunk = 8'(buf_reg >> sh) & nmask;
        pos   = 3'(k - n);
        res   = (s_tdata & ~(nmask << pos)) | (chunk << pos);
        cnt_e = cnt_reg - {1'b0, n};

        // Extract: append K low bits, emit when a byte is complete.
        cnt_b   = (cnt_reg > 5'd7) ? '0 : cnt_reg;
        buf_b   = (cnt_reg > 5'd7) ? '0 : buf_reg;
        ext_buf = (buf_b << k) | {8'd0, s_tdata & kmask};
        ext_cnt = cnt_b + {1'b0, k};
        ext_rem = ext_cnt - 5'd8;

        mode_next = mode_reg;
        bpc_next  = bpc_reg;
        plen_next = plen_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        bcnt_next = bcnt_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_need_next  = m_need_reg;
        m_under_next = m_under_reg;
        m_done_next  = m_done_reg;

        if (cfg_wr && cfg_idx inside {REG_MODE_SEL, REG_BITS_PER, REG_PAY_LEN}) begin
            case (cfg_idx)
                REG_MODE_SEL: mode_next = pwdata[0];
                REG_BITS_PER: bpc_next  = pwdata[K_W-1:0];
                REG_PAY_LEN:  plen_next = pwdata;
                default:      ;
            endcase
            buf_next  = '0;
            cnt_next  = '0;
            bcnt_next = '0;
        end else if (accept) begin
            if (mode_reg == MODE_EMBED) begin
                if (s_tuser[0] == CMD_SECRET) begin
                    if (!all_pushed && cnt_reg <= 5'd8) begin
                        buf_next  = {buf_reg[7:0], s_tdata};
                        cnt_next  = cnt_reg + 5'd8;
                        bcnt_next = bcnt_reg + 32'd1;
                    end
                end else begin
                    m_valid_next = 1'b1;
                    m_data_next  = s_tdata;
                    m_under_next = 1'b0;
                    if (!all_pushed && cnt_reg < {1'b0, k}) begin
                        // Not enough secret bits yet: pass through and flag it.
                        m_under_next = 1'b1;
                    end else if (cnt_reg != '0) begin
                        m_data_next = res;
                        cnt_next    = cnt_e;
                        buf_next    = buf_reg & 16'((17'd1 << cnt_e) - 17'd1);
                    end
                    m_need_next = (cnt_next < {1'b0, k}) && !all_pushed;
                    m_done_next = all_pushed && (cnt_next == '0);
                end
            end else if (s_tuser[0] == CMD_COVER && !all_pushed) begin
                buf_next = ext_buf;
                cnt_next = ext_cnt;
                if (ext_cnt >= 5'd8) begin
                    m_valid_next = 1'b1;
                    m_data_next  = 8'(ext_buf >> ext_rem[3:0]);
                    m_need_next  = 1'b0;
                    m_under_next = 1'b0;
                    m_done_next  = (bcnt_reg + 32'd1) >= plen_reg;
                    cnt_next     = ext_rem;
                    buf_next     = ext_buf & 16'((17'd1 << ext_rem) - 17'd1);
                    bcnt_next    = bcnt_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_EMBED;
            bpc_reg     <= K_MIN;
            plen_reg    <= '0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            bcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            bpc_reg     <= bpc_next;
            plen_reg    <= plen_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            bcnt_reg    <= bcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        m_need_reg  <= m_need_next;
        m_under_reg <= m_under_next;
        m_done_reg  <= m_done_next;
    end

    // The buffer never holds more than two secret bytes.
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 5'd16)
        else $error("bit count exceeds buffer size");

    // The byte counter stops at the payload length.
    assert property (@(posedge aclk) disable iff (!aresetn) bcnt_reg <= plen_reg)
        else $error("byte counter passed payload length");

    // In extract mode a completed byte always leaves the buffer right away.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_EXTRACT |-> cnt_reg < 5'd8)
        else $error("extract buffer kept a full byte");

    // An underrun means secret bytes remain, so the payload cannot be done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_under_reg |-> !m_done_reg)
        else $error("underrun reported together with done");

endmodule
